FILE: design/aiabp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aiabp_pkg
// Types, codes and character helpers for the auto-base integer parser.
// ----------------------------------------------------------------------------
package aiabp_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned ValueWidth = 16;
   localparam int unsigned BaseWidth  = 2;

   localparam logic [CharWidth-1:0] CharNul   = 8'h00;
   localparam logic [CharWidth-1:0] CharSpace = 8'h20;
   localparam logic [CharWidth-1:0] CharTab   = 8'h09;
   localparam logic [CharWidth-1:0] CharCr    = 8'h0d;
   localparam logic [CharWidth-1:0] CharZero  = 8'h30;
   localparam logic [CharWidth-1:0] CharSeven = 8'h37;
   localparam logic [CharWidth-1:0] CharNine  = 8'h39;
   localparam logic [CharWidth-1:0] CharLowA  = 8'h61;
   localparam logic [CharWidth-1:0] CharLowF  = 8'h66;
   localparam logic [CharWidth-1:0] CharUpA   = 8'h41;
   localparam logic [CharWidth-1:0] CharUpF   = 8'h46;
   localparam logic [CharWidth-1:0] CharLowX  = 8'h78;
   localparam logic [CharWidth-1:0] CharUpX   = 8'h58;

   typedef enum logic [1:0] {
      PHASE_BLANK   = 2'd0,
      PHASE_ZERO    = 2'd1,
      PHASE_DIGITS  = 2'd2,
      PHASE_SWALLOW = 2'd3
   } phase_type;

   typedef enum logic [BaseWidth-1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2
   } radix_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } digit_type;

   function automatic logic is_blank(input logic [CharWidth-1:0] c);
      return (c == CharSpace) || (c >= CharTab && c <= CharCr);
   endfunction

   function automatic digit_type decode_digit(input logic [CharWidth-1:0] c,
                                              input radix_type radix);
      digit_type d;
      logic [CharWidth-1:0] off;
      d   = '0;
      off = '0;
      case (radix)
         RADIX_OCT: begin
            if (c >= CharZero && c <= CharSeven) begin
               off = c - CharZero;
               d.ok = 1'b1;
            end
         end
         RADIX_HEX: begin
            if (c >= CharZero && c <= CharNine) begin
               off = c - CharZero;
               d.ok = 1'b1;
            end else if (c >= CharLowA && c <= CharLowF) begin
               off = c - CharLowA + 8'd10;
               d.ok = 1'b1;
            end else if (c >= CharUpA && c <= CharUpF) begin
               off = c - CharUpA + 8'd10;
               d.ok = 1'b1;
            end
         end
         default: begin
            if (c >= CharZero && c <= CharNine) begin
               off = c - CharZero;
               d.ok = 1'b1;
            end
         end
      endcase
      d.value = off[3:0];
      return d;
   endfunction

endpackage
`default_nettype wire

FILE: design/aiabp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aiabp channel interfaces
// Valid/ready channels for characters in and parsed numbers out.
// ----------------------------------------------------------------------------
interface aiabp_req_if import aiabp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface aiabp_rsp_if import aiabp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ValueWidth-1:0] number_value;
   logic                  ended_by_invalid;
   logic [BaseWidth-1:0]  base_used;

   modport source (output valid, output number_value, output ended_by_invalid,
                   output base_used, input ready);
   modport sink   (input valid, input number_value, input ended_by_invalid,
                   input base_used, output ready);
endinterface
`default_nettype wire

FILE: design/ascii_integer_auto_base_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_integer_auto_base_parser
// Folds a stream of ASCII characters into 16-bit numbers, picking decimal,
// octal or hex from the prefix.
// ----------------------------------------------------------------------------
//  channel    dir  word
//  req_chan   in   char_code[7:0]
//  rsp_chan   out  number_value[15:0], ended_by_invalid, base_used[1:0]
//
//  one character per cycle unless the output stalls; a result for a number's
//  ending character passes the input register, then the result register
//  the character register advances whenever the result register is empty or
//  being drained, so a stalled output holds at most one further character
//  synchronous reset returns to the whitespace phase, decimal, value zero
// ----------------------------------------------------------------------------
module ascii_integer_auto_base_parser
   import aiabp_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   aiabp_req_if.sink  req_chan,
   aiabp_rsp_if.source rsp_chan
);

   logic                  in_valid_ff, in_valid_in;
   logic [CharWidth-1:0]  in_char_ff;
   phase_type             phase_ff, phase_in;
   radix_type             radix_ff, radix_in;
   logic [ValueWidth-1:0] acc_ff, acc_in;
   logic                  out_valid_ff, out_valid_in;
   logic [ValueWidth-1:0] out_value_ff, out_value_in;
   logic                  out_invalid_ff, out_invalid_in;
   radix_type             out_base_ff, out_base_in;

   logic                  advance;
   logic                  req_take;
   logic                  emit;
   radix_type             step_radix;
   digit_type             dig;
   logic [ValueWidth-1:0] scaled;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in = req_take || (in_valid_ff && !advance);

   // radix the digit step runs in: a prefix phase fixes it
   always_comb begin
      case (phase_ff)
         PHASE_ZERO:   step_radix = RADIX_OCT;
         PHASE_DIGITS: step_radix = radix_ff;
         default:      step_radix = RADIX_DEC;
      endcase
   end

   assign dig = decode_digit(in_char_ff, step_radix);

   always_comb begin
      case (step_radix)
         RADIX_OCT: scaled = {acc_ff[ValueWidth-4:0], 3'b000};
         RADIX_HEX: scaled = {acc_ff[ValueWidth-5:0], 4'b0000};
         default:   scaled = {acc_ff[ValueWidth-4:0], 3'b000}
                           + {acc_ff[ValueWidth-2:0], 1'b0};
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      radix_in       = radix_ff;
      acc_in         = acc_ff;
      emit           = 1'b0;
      out_value_in   = acc_ff;
      out_invalid_in = 1'b0;
      out_base_in    = step_radix;
      if (advance) begin
         case (phase_ff)
            PHASE_SWALLOW: begin
               if (in_char_ff == CharNul) begin
                  phase_in = PHASE_BLANK;
                  radix_in = RADIX_DEC;
                  acc_in   = '0;
               end
            end
            default: begin
               if (phase_ff == PHASE_ZERO
                   && (in_char_ff == CharLowX || in_char_ff == CharUpX)) begin
                  radix_in = RADIX_HEX;
                  phase_in = PHASE_DIGITS;
               end else if (phase_ff == PHASE_BLANK && is_blank(in_char_ff)) begin
                  phase_in = PHASE_BLANK;
               end else if (phase_ff == PHASE_BLANK && in_char_ff == CharZero) begin
                  acc_in   = '0;
                  phase_in = PHASE_ZERO;
               end else if (in_char_ff == CharNul) begin
                  emit     = 1'b1;
                  phase_in = PHASE_BLANK;
                  radix_in = RADIX_DEC;
                  acc_in   = '0;
               end else if (!dig.ok) begin
                  emit           = 1'b1;
                  out_invalid_in = 1'b1;
                  radix_in       = step_radix;
                  phase_in       = PHASE_SWALLOW;
               end else begin
                  acc_in   = scaled + {{(ValueWidth-4){1'b0}}, dig.value};
                  radix_in = step_radix;
                  phase_in = PHASE_DIGITS;
               end
            end
         endcase
      end
   end

   assign out_valid_in = emit || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PHASE_BLANK;
         radix_ff     <= RADIX_DEC;
         acc_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         radix_ff     <= radix_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_chan.char_code;
      end
      if (emit) begin
         out_value_ff   <= out_value_in;
         out_invalid_ff <= out_invalid_in;
         out_base_ff    <= out_base_in;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.number_value     = out_value_ff;
   assign rsp_chan.ended_by_invalid = out_invalid_ff;
   assign rsp_chan.base_used        = out_base_ff;

endmodule
`default_nettype wire

FILE: design/aiabp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aiabp_checker
// Port-level checks on the parser's handshakes and timing.
// ----------------------------------------------------------------------------
module aiabp_checker
   import aiabp_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [ValueWidth-1:0] rsp_number_value,
   input wire logic                  rsp_ended_by_invalid,
   input wire logic [BaseWidth-1:0]  rsp_base_used
);

   // a held word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_number_value)
         && $stable(rsp_ended_by_invalid) && $stable(rsp_base_used))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input side only back-pressures when the result register is stuck
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output stall");

   // a fresh result needs a character taken into the input register ahead of it
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a matching character");

endmodule

bind ascii_integer_auto_base_parser aiabp_checker u_aiabp_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_chan.valid),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_number_value     (rsp_chan.number_value),
   .rsp_ended_by_invalid (rsp_chan.ended_by_invalid),
   .rsp_base_used        (rsp_chan.base_used)
);
`default_nettype wire
